@@ src/iss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the indexed sequence store.
// Used by iss_ctrl, iss_datapath and indexed_sequence_store_core; no dependencies.
package iss_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 3;
    localparam int POS_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ     = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_INS_POS  = 3'd3,
        MODE_DELETE   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        OP_REJECT = 2'd0,
        OP_READ   = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic shift;
        logic rd;
        logic put;
        logic done;
    } t_ctrl_cmd;

    typedef struct packed {
        t_op  new_op;
        t_op  op;
        logic shift_done;
    } t_dp_stat;

endpackage

@@ src/indexed_sequence_store_core.sv @@
`timescale 1ns / 1ps
// Indexed sequence store: a word is taken when start is high and busy is low, and one
// result word follows, marked by o_strobe for one cycle; the receiver cannot stall.
// A refused word goes to the done state, a read through the read state, and an insert
// or a delete through the shift state, one entry per cycle through the memory port; an
// insert then writes its item. The next word is taken in the cycle the strobe is shown.
// Reset (synchronous, active low) empties the store, clears o_strobe and idles the FSM.
module indexed_sequence_store_core import iss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [POS_W-1:0]   i_position,
    input  logic signed [VALUE_W-1:0] i_item_value,
    output logic                      o_strobe,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic                      o_read_valid,
    output logic                      o_rejected,
    output logic [LEN_W-1:0]          o_list_length
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    iss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    iss_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_stat        (stat),
        .o_read_value  (o_read_value),
        .o_read_valid  (o_read_valid),
        .o_rejected    (o_rejected),
        .o_list_length (o_list_length),
        .o_strobe      (o_strobe)
    );

endmodule

@@ src/iss_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the indexed sequence store.
// Depends on iss_pkg; drives the datapath through t_ctrl_cmd and reads t_dp_stat.
module iss_ctrl import iss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd,
    output logic      busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_PUT   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_stat.new_op)
                        OP_READ:   n_state = S_READ;
                        OP_INSERT: n_state = S_SHIFT;
                        OP_DELETE: n_state = S_SHIFT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = (i_stat.op == OP_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ src/iss_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the indexed sequence store: request decode, entry memory,
// shift engine, length register and result registers. Depends on iss_pkg.
module iss_datapath import iss_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl_cmd                 i_cmd,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [POS_W-1:0]   i_position,
    input  logic signed [VALUE_W-1:0] i_item_value,
    output t_dp_stat                  o_stat,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic                      o_read_valid,
    output logic                      o_rejected,
    output logic [LEN_W-1:0]          o_list_length,
    output logic                      o_strobe
);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]   r_count;
    t_op                r_op;
    logic [ADDR_W-1:0]  r_at;
    logic [VALUE_W-1:0] r_val;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [CNT_W-1:0]   r_remain;
    logic               r_wr_pend;
    logic [VALUE_W-1:0] r_rdata;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_valid;
    logic               r_out_rej;
    logic [CNT_W-1:0]   r_out_len;
    logic               r_strobe;

    logic [CNT_W-1:0]   n_count;

    // Request decode.
    logic              pos_neg;
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  cnt_ext;
    logic              in_range;
    logic              full;
    t_op               dec_op;
    logic [ADDR_W-1:0] dec_at;

    assign pos_neg  = i_position[POS_W-1];
    assign pos_u    = POS_W'(unsigned'(i_position));
    assign cnt_ext  = POS_W'(r_count);
    assign in_range = !pos_neg && (pos_u < cnt_ext);
    assign full     = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        dec_op = OP_REJECT;
        dec_at = pos_u[ADDR_W-1:0];
        case (i_mode)
            MODE_READ: begin
                dec_op = in_range ? OP_READ : OP_REJECT;
            end
            MODE_INS_HEAD: begin
                dec_op = full ? OP_REJECT : OP_INSERT;
                dec_at = '0;
            end
            MODE_INS_TAIL: begin
                dec_op = full ? OP_REJECT : OP_INSERT;
                dec_at = r_count[ADDR_W-1:0];
            end
            MODE_INS_POS: begin
                if ((!pos_neg && (pos_u > cnt_ext)) || full) begin
                    dec_op = OP_REJECT;
                end else begin
                    dec_op = OP_INSERT;
                end
                if (pos_neg) begin
                    dec_at = '0;
                end
            end
            MODE_DELETE: begin
                dec_op = in_range ? OP_DELETE : OP_REJECT;
            end
            default: begin
                dec_op = OP_REJECT;
            end
        endcase
    end

    // Memory port selection: one write and one read per cycle.
    logic               shift_rd;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [VALUE_W-1:0] mem_wd;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_ra;

    assign shift_rd = i_cmd.shift && (r_remain != '0);
    assign mem_we   = (i_cmd.shift && r_wr_pend) || i_cmd.put;
    assign mem_wa   = i_cmd.put ? r_at : r_wr_addr;
    assign mem_wd   = i_cmd.put ? r_val : r_rdata;
    assign mem_re   = i_cmd.rd || shift_rd;
    assign mem_ra   = i_cmd.rd ? r_at : r_src;

    // The shift read and the write-back never address the same word.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // Request registers and shift engine.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= dec_op;
            r_at  <= dec_at;
            r_val <= i_item_value;
            if (dec_op == OP_INSERT) begin
                r_remain <= r_count - CNT_W'(dec_at);
                r_src    <= r_count[ADDR_W-1:0] - ADDR_W'(1);
            end else begin
                r_remain <= r_count - CNT_W'(dec_at) - CNT_W'(1);
                r_src    <= dec_at + ADDR_W'(1);
            end
        end else if (shift_rd) begin
            r_remain <= r_remain - CNT_W'(1);
            if (r_op == OP_INSERT) begin
                r_wr_addr <= r_src + ADDR_W'(1);
                r_src     <= r_src - ADDR_W'(1);
            end else begin
                r_wr_addr <= r_src - ADDR_W'(1);
                r_src     <= r_src + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_wr_pend <= 1'b0;
        end else if (i_cmd.shift) begin
            r_wr_pend <= shift_rd;
        end
    end

    always_comb begin
        n_count = r_count;
        case (r_op)
            OP_INSERT: n_count = r_count + CNT_W'(1);
            OP_DELETE: n_count = r_count - CNT_W'(1);
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
            if (i_cmd.done) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_value <= (r_op == OP_READ) ? r_rdata : '0;
            r_out_valid <= (r_op == OP_READ);
            r_out_rej   <= (r_op == OP_REJECT);
            r_out_len   <= n_count;
        end
    end

    assign o_stat.new_op     = dec_op;
    assign o_stat.op         = r_op;
    assign o_stat.shift_done = (r_remain == '0) && !r_wr_pend;

    assign o_read_value  = signed'(r_out_value);
    assign o_read_valid  = r_out_valid;
    assign o_rejected    = r_out_rej;
    assign o_list_length = LEN_W'(r_out_len);
    assign o_strobe      = r_strobe;

endmodule

@@ tb/indexed_sequence_store_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequence_store_core: directed and random words
// go in through start/busy, and every result word is checked against a behavioral store.
// Depends on iss_pkg and the indexed_sequence_store_core RTL.
module indexed_sequence_store_core_tb;
    import iss_pkg::*;

    localparam int RANDOM_WORDS   = 1800;
    localparam int DRAIN_CYCLES   = 2 * (CAPACITY + 4);
    localparam int WATCHDOG_LIMIT = 20 * (CAPACITY + 4 + 6);
    localparam int PHASE_GROW     = 0;
    localparam int PHASE_SHRINK   = 1;
    localparam int PHASE_MIXED    = 2;

    localparam logic [MODE_W-1:0]         MODE_UNUSED_FIRST = 3'd5;
    localparam logic signed [POS_W-1:0]   POS_MIN = 16'sh8000;
    localparam logic signed [POS_W-1:0]   POS_MAX = 16'sh7fff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [POS_W-1:0]   position;
        logic signed [VALUE_W-1:0] item_value;
        int                        gap;
    } request_t;

    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        logic                      read_valid;
        logic                      rejected;
        logic [LEN_W-1:0]          list_length;
    } outcome_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode = '0;
    logic signed [POS_W-1:0]   i_position = '0;
    logic signed [VALUE_W-1:0] i_item_value = '0;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_read_value;
    logic                      o_read_valid;
    logic                      o_rejected;
    logic [LEN_W-1:0]          o_list_length;

    indexed_sequence_store_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_strobe      (o_strobe),
        .o_read_value  (o_read_value),
        .o_read_valid  (o_read_valid),
        .o_rejected    (o_rejected),
        .o_list_length (o_list_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioral copy of the store, advanced once per accepted word.
    logic signed [VALUE_W-1:0] shadow_cells [CAPACITY];
    int shadow_len = 0;
    int n_words = 0, n_reads = 0, n_inserts = 0, n_deletes = 0, n_refused = 0, n_full = 0;

    function automatic outcome_t apply_request(logic [MODE_W-1:0] mode,
                                               logic signed [POS_W-1:0] pos,
                                               logic signed [VALUE_W-1:0] val);
        outcome_t res;
        int       at;
        bit       is_insert;
        res.read_value = '0;
        res.read_valid = 1'b0;
        res.rejected   = 1'b1;
        at = -1;
        is_insert = 1'b0;
        case (mode)
            MODE_READ: begin
                if (pos >= 0 && pos < shadow_len) begin
                    res.read_value = shadow_cells[int'(pos)];
                    res.read_valid = 1'b1;
                    res.rejected   = 1'b0;
                    n_reads++;
                end
            end
            MODE_INS_HEAD: begin
                is_insert = 1'b1;
                at = 0;
            end
            MODE_INS_TAIL: begin
                is_insert = 1'b1;
                at = shadow_len;
            end
            MODE_INS_POS: begin
                is_insert = 1'b1;
                at = (pos < 0) ? 0 : ((pos <= shadow_len) ? int'(pos) : -1);
            end
            MODE_DELETE: begin
                if (pos >= 0 && pos < shadow_len) begin
                    for (int i = int'(pos); i < shadow_len - 1; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_len--;
                    res.rejected = 1'b0;
                    n_deletes++;
                end
            end
            default: ;
        endcase
        if (is_insert && at >= 0) begin
            if (shadow_len >= CAPACITY) begin
                n_full++;
            end else begin
                for (int i = shadow_len; i > at; i--)
                    shadow_cells[i] = shadow_cells[i - 1];
                shadow_cells[at] = val;
                shadow_len++;
                res.rejected = 1'b0;
                n_inserts++;
            end
        end
        if (res.rejected)
            n_refused++;
        n_words++;
        res.list_length = LEN_W'(shadow_len);
        return res;
    endfunction

    // Stimulus generation.
    request_t pending [$];
    int       gen_len = 0;
    bit       calm = 1'b0;

    function automatic void queue_word(logic [MODE_W-1:0] mode, logic signed [POS_W-1:0] pos,
                                       logic signed [VALUE_W-1:0] val);
        request_t req;
        req.mode       = mode;
        req.position   = pos;
        req.item_value = val;
        req.gap        = calm ? 0 : $urandom_range(0, 6);
        pending.push_back(req);
        // Follow the length so that random positions land mostly in range.
        case (mode)
            MODE_INS_HEAD, MODE_INS_TAIL: if (gen_len < CAPACITY) gen_len++;
            MODE_INS_POS: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
            MODE_DELETE: if (pos >= 0 && pos < gen_len) gen_len--;
            default: ;
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position(int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 78 && top >= 0) return POS_W'($urandom_range(0, top));
        if (r < 84) return POS_W'(top + 1);
        if (r < 88) return '1;
        if (r < 91) return POS_MIN;
        if (r < 93) return POS_MAX;
        return POS_W'($urandom);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Driver: presents one word at a time and holds it until it is taken.
    int idle_count = 0;
    bit word_taken = 1'b0;

    always @(negedge i_clk) begin : drive_proc
        logic     next_start;
        request_t req;
        next_start = start;
        if (i_rst_n) begin
            if (start && word_taken)
                next_start = 1'b0;
            if (!next_start && pending.size() > 0) begin
                if (idle_count >= pending[0].gap) begin
                    req = pending.pop_front();
                    i_mode       <= req.mode;
                    i_position   <= req.position;
                    i_item_value <= req.item_value;
                    next_start = 1'b1;
                    idle_count = 0;
                end else begin
                    idle_count++;
                end
            end
        end
        start <= next_start;
    end

    // Monitor: checks result words, predicts accepted words, and runs the watchdog.
    outcome_t expected_results [$];
    int       mismatch_count = 0;
    int       quiet_cycles = 0;

    always @(posedge i_clk) begin : check_proc
        outcome_t want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d", want.read_value, o_read_value);
                        mismatch_count++;
                    end
                    if (o_read_valid !== want.read_valid) begin
                        $error("read_valid: expected %0d, got %0d", want.read_valid, o_read_valid);
                        mismatch_count++;
                    end
                    if (o_rejected !== want.rejected) begin
                        $error("rejected: expected %0d, got %0d", want.rejected, o_rejected);
                        mismatch_count++;
                    end
                    if (o_list_length !== want.list_length) begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, o_list_length);
                        mismatch_count++;
                    end
                end
            end
            word_taken = start && !busy;
            if (word_taken)
                expected_results.push_back(apply_request(i_mode, i_position, i_item_value));
            if (o_strobe || word_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end else begin
            word_taken = 1'b0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: timeout after %0d cycles without a word moving", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : main_proc
        int phase, phase_left, calm_left, roll, ins_pct, del_pct;
        phase = PHASE_GROW;
        phase_left = 0;
        calm_left = 0;

        // Directed words: empty store, every mode, edge positions and edge values.
        queue_word(MODE_READ, '0, '0);
        queue_word(MODE_DELETE, '0, '0);
        queue_word(MODE_INS_POS, 16'sd1, 32'sd9);
        queue_word(MODE_INS_POS, '0, 32'sd5);
        queue_word(MODE_INS_HEAD, '0, VAL_MAX);
        queue_word(MODE_INS_TAIL, POS_MAX, VAL_MIN);
        queue_word(MODE_INS_POS, POS_MIN, '0);
        queue_word(MODE_INS_POS, 16'sd4, '1);
        queue_word(MODE_INS_POS, 16'sd2, 32'sd12345);
        queue_word(MODE_INS_POS, 16'sd7, 32'sd1);
        queue_word(MODE_READ, '0, '0);
        queue_word(MODE_READ, 16'sd5, '0);
        queue_word(MODE_READ, 16'sd6, '0);
        queue_word(MODE_READ, '1, '0);
        queue_word(MODE_READ, POS_MAX, '1);
        queue_word(MODE_DELETE, '1, '0);
        queue_word(MODE_DELETE, 16'sd6, '0);
        queue_word(MODE_DELETE, 16'sd5, '0);
        queue_word(MODE_DELETE, '0, '0);
        queue_word(MODE_DELETE, 16'sd2, '0);
        queue_word(MODE_UNUSED_FIRST, '0, '1);
        queue_word(MODE_W'(MODE_UNUSED_FIRST + 1), '1, VAL_MAX);
        queue_word(MODE_W'(MODE_UNUSED_FIRST + 2), POS_MIN, VAL_MIN);
        queue_word(MODE_READ, 16'sd1, '0);

        // Random words in phases that fill the store, drain it, or churn it.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase_left == 0) begin
                phase = $urandom_range(PHASE_GROW, PHASE_MIXED);
                phase_left = $urandom_range(60, 220);
            end
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 80);
            end
            phase_left--;
            calm_left--;
            ins_pct = (phase == PHASE_GROW) ? 65 : ((phase == PHASE_SHRINK) ? 15 : 30);
            del_pct = (phase == PHASE_SHRINK) ? 65 : ((phase == PHASE_GROW) ? 15 : 30);
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                queue_word(MODE_W'(MODE_UNUSED_FIRST + $urandom_range(0, 2)),
                           POS_W'($urandom), pick_value());
            end else if (roll < 5 + ins_pct) begin
                case ($urandom_range(0, 2))
                    0: queue_word(MODE_INS_HEAD, POS_W'($urandom), pick_value());
                    1: queue_word(MODE_INS_TAIL, POS_W'($urandom), pick_value());
                    default: queue_word(MODE_INS_POS, pick_position(gen_len), pick_value());
                endcase
            end else if (roll < 5 + ins_pct + del_pct) begin
                queue_word(MODE_DELETE, pick_position(gen_len - 1), pick_value());
            end else begin
                queue_word(MODE_READ, pick_position(gen_len - 1), pick_value());
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d words checked: %0d valid reads, %0d inserts, %0d deletes, %0d refused",
                 n_words, n_reads, n_inserts, n_deletes, n_refused);
        $display("tb: %0d inserts were turned away by a store holding %0d entries",
                 n_full, CAPACITY);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
